@@ hdl/atac_pkg.sv @@
// ----------------------------------------------------------------------------
// atac_pkg
// Shared types and constants for the auth token alias cache.
// ----------------------------------------------------------------------------
package atac_pkg;

    // Accounted size of one entry is this overhead plus its value length.
    localparam logic [16:0] ENTRY_OVERHEAD = 17'd16;
    localparam logic [31:0] BUDGET_RESET   = 32'd4096;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_PROTOCOL  = 3'd2,
        ST_UNKNOWN   = 3'd3,
        ST_DUPLICATE = 3'd4,
        ST_OVERFLOW  = 3'd5,
        ST_EXPIRED   = 3'd6,
        ST_FULL      = 3'd7
    } status_t;

    typedef enum logic {
        OP_APPLY = 1'b0,
        OP_MARK  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        AK_DELETE    = 2'd0,
        AK_REGISTER  = 2'd1,
        AK_USE_ALIAS = 2'd2,
        AK_USE_VALUE = 2'd3
    } alias_kind_t;

    typedef struct packed {
        logic        opcode;
        logic [1:0]  alias_kind;
        logic        alias_present;
        logic        type_present;
        logic [63:0] alias_number;
        logic [63:0] token_kind;
        logic [15:0] value_handle;
        logic [15:0] value_bytes;
        logic        during_setup;
        logic        at_server;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic        resolved_valid;
        logic [63:0] resolved_kind;
        logic [15:0] resolved_handle;
        logic [15:0] resolved_bytes;
        logic        newly_registered;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic match;
        logic select;
        logic execute;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic rsp_pending;
    } sts_t;

endpackage

@@ hdl/atac_if.sv @@
// ----------------------------------------------------------------------------
// atac_if
// Valid/ready channels of the alias cache: request and response.
// ----------------------------------------------------------------------------
interface atac_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [1:0]  alias_kind;
    logic        alias_present;
    logic        type_present;
    logic [63:0] alias_number;
    logic [63:0] token_kind;
    logic [15:0] value_handle;
    logic [15:0] value_bytes;
    logic        during_setup;
    logic        at_server;

    modport source (
        output valid, opcode, alias_kind, alias_present, type_present, alias_number,
               token_kind, value_handle, value_bytes, during_setup, at_server,
        input  ready
    );
    modport sink (
        input  valid, opcode, alias_kind, alias_present, type_present, alias_number,
               token_kind, value_handle, value_bytes, during_setup, at_server,
        output ready
    );
endinterface

interface atac_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        resolved_valid;
    logic [63:0] resolved_kind;
    logic [15:0] resolved_handle;
    logic [15:0] resolved_bytes;
    logic        newly_registered;

    modport source (
        output valid, status, resolved_valid, resolved_kind, resolved_handle,
               resolved_bytes, newly_registered,
        input  ready
    );
    modport sink (
        input  valid, status, resolved_valid, resolved_kind, resolved_handle,
               resolved_bytes, newly_registered,
        output ready
    );
endinterface

@@ hdl/auth_token_alias_cache_unit.sv @@
// Flow: after the request transfer the item passes the match, select and execute
//   steps; execute waits only while an earlier response is not taken.
// One item at a time, set by the controller's four-step walk through the alias
//   compare, the slot select and the entry RAM read.
// Reset (rst_n, async, active low): table empty, used bytes zero, budget 4096.
// ----------------------------------------------------------------------------
// auth_token_alias_cache_unit
// Token alias table with byte-budget accounting: register, delete, resolve,
// pass-through and mark-expired, one response per request.
// ----------------------------------------------------------------------------
module auth_token_alias_cache_unit
    import atac_pkg::*;
#(
    parameter int SLOTS       = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    atac_req_if.sink    req,
    atac_rsp_if.source  rsp
);

    cmd_t cmd;
    sts_t sts;
    req_t req_payload;
    rsp_t rsp_payload;

    // Request payload packed for the datapath capture register.
    assign req_payload.opcode        = req.opcode;
    assign req_payload.alias_kind    = req.alias_kind;
    assign req_payload.alias_present = req.alias_present;
    assign req_payload.type_present  = req.type_present;
    assign req_payload.alias_number  = req.alias_number;
    assign req_payload.token_kind    = req.token_kind;
    assign req_payload.value_handle  = req.value_handle;
    assign req_payload.value_bytes   = req.value_bytes;
    assign req_payload.during_setup  = req.during_setup;
    assign req_payload.at_server     = req.at_server;

    // Controller: walks each accepted item through the datapath steps and
    // stalls in execute while the output register still holds a result.
    atac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: alias compare across all slots, priority select of the hit
    // and of the first free slot, budget test, entry RAM, output register.
    atac_dpath #(
        .SLOTS       (SLOTS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_payload),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .rsp         (rsp_payload)
    );

    // Response payload unpacked onto the channel.
    assign rsp.status           = rsp_payload.status;
    assign rsp.resolved_valid   = rsp_payload.resolved_valid;
    assign rsp.resolved_kind    = rsp_payload.resolved_kind;
    assign rsp.resolved_handle  = rsp_payload.resolved_handle;
    assign rsp.resolved_bytes   = rsp_payload.resolved_bytes;
    assign rsp.newly_registered = rsp_payload.newly_registered;

endmodule

@@ hdl/atac_ram.sv @@
// ----------------------------------------------------------------------------
// atac_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module atac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/atac_ctrl.sv @@
// ----------------------------------------------------------------------------
// atac_ctrl
// Sequencer: capture, match, select, execute; one item at a time.
// ----------------------------------------------------------------------------
module atac_ctrl
    import atac_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MATCH = 4'b0010,
        S_SEL   = 4'b0100,
        S_EXEC  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH: state_next = S_SEL;
            S_SEL:   state_next = S_EXEC;
            S_EXEC:
            begin
                // hold while the previous result still sits in the output register
                if (!sts.rsp_pending)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready   = (state_reg == S_IDLE);
    assign cmd.capture = (state_reg == S_IDLE) && req_valid;
    assign cmd.match   = (state_reg == S_MATCH);
    assign cmd.select  = (state_reg == S_SEL);
    assign cmd.execute = (state_reg == S_EXEC) && !sts.rsp_pending;

endmodule

@@ hdl/atac_dpath.sv @@
// ----------------------------------------------------------------------------
// atac_dpath
// Alias table, budget accounting and output register of the alias cache.
// ----------------------------------------------------------------------------
module atac_dpath
    import atac_pkg::*;
#(
    parameter int SLOTS       = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ENT_W = 64 + 16 + 16;
    localparam logic [15:0] HANDLE_MASK =
        (HANDLE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << HANDLE_BITS) - 32'd1);

    // captured item
    req_t        req_in;
    req_t        item_reg;

    // table state
    logic [SLOTS-1:0] used_reg;
    logic [SLOTS-1:0] expired_reg;
    logic [63:0]      alias_reg [SLOTS];
    logic [31:0]      used_bytes_reg;
    logic [31:0]      budget_reg;

    // lookup pipeline
    logic [SLOTS-1:0] match_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             free_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             fits_reg;

    logic             hit_next;
    logic [IDX_W-1:0] hit_idx_next;
    logic             free_next;
    logic [IDX_W-1:0] free_idx_next;
    logic             fits_next;
    logic [31:0]      esize;

    // entry store: {kind, handle, bytes}
    logic             ram_we;
    logic [ENT_W-1:0] ram_rdata;
    logic [63:0]      rd_kind;
    logic [15:0]      rd_handle;
    logic [15:0]      rd_bytes;

    // execute results
    rsp_t             res;
    logic             item_ok;
    logic             do_delete;
    logic             do_store;
    logic             do_mark;

    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    assign esize = 32'({1'b0, item_reg.value_bytes} + ENTRY_OVERHEAD);

    // ---- capture ----
    // handle masked on the way in
    always_comb
    begin
        req_in              = req;
        req_in.value_handle = req.value_handle & HANDLE_MASK;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req_in;
        end
    end

    // ---- budget register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= BUDGET_RESET;
        end
        else if (cfg_wr_en)
        begin
            budget_reg <= cfg_wr_data;
        end
    end

    // ---- match: compare all used slots ----
    always_ff @(posedge clk)
    begin
        if (cmd.match)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                match_reg[i] <= used_reg[i] && (alias_reg[i] == item_reg.alias_number);
            end
        end
    end

    // ---- select: lowest matching slot, lowest free slot, budget test ----
    always_comb
    begin
        hit_next      = 1'b0;
        hit_idx_next  = '0;
        free_next     = 1'b0;
        free_idx_next = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit_next     = 1'b1;
                hit_idx_next = IDX_W'(i);
            end
            if (!used_reg[i])
            begin
                free_next     = 1'b1;
                free_idx_next = IDX_W'(i);
            end
        end
        fits_next = !((esize > budget_reg) || (used_bytes_reg > (budget_reg - esize)));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.select)
        begin
            hit_reg      <= hit_next;
            hit_idx_reg  <= hit_idx_next;
            free_reg     <= free_next;
            free_idx_reg <= free_idx_next;
            fits_reg     <= fits_next;
        end
    end

    atac_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx_reg),
        .wdata ({item_reg.token_kind, item_reg.value_handle, item_reg.value_bytes}),
        .re    (cmd.select),
        .raddr (hit_idx_next),
        .rdata (ram_rdata)
    );

    assign rd_kind   = ram_rdata[ENT_W-1 -: 64];
    assign rd_handle = ram_rdata[31:16];
    assign rd_bytes  = ram_rdata[15:0];

    // ---- execute ----
    always_comb
    begin
        res                  = '0;
        res.status           = ST_OK;
        do_delete            = 1'b0;
        do_store             = 1'b0;
        do_mark              = 1'b0;
        item_ok              = 1'b0;

        unique case (alias_kind_t'(item_reg.alias_kind))
            AK_DELETE, AK_USE_ALIAS:
                item_ok = item_reg.alias_present && !item_reg.type_present
                          && (item_reg.value_bytes == 16'd0);
            AK_REGISTER:
                item_ok = item_reg.alias_present && item_reg.type_present;
            AK_USE_VALUE:
                item_ok = !item_reg.alias_present && item_reg.type_present;
            default:
                item_ok = 1'b0;
        endcase

        if (opcode_t'(item_reg.opcode) == OP_MARK)
        begin
            if (hit_reg)
            begin
                do_mark = 1'b1;
            end
            else
            begin
                res.status = ST_UNKNOWN;
            end
        end
        else if (!item_ok)
        begin
            res.status = ST_INVALID;
        end
        else if (item_reg.during_setup && item_reg.at_server
                 && (alias_kind_t'(item_reg.alias_kind) == AK_DELETE
                     || alias_kind_t'(item_reg.alias_kind) == AK_USE_ALIAS))
        begin
            res.status = ST_PROTOCOL;
        end
        else
        begin
            unique case (alias_kind_t'(item_reg.alias_kind))
                AK_DELETE:
                begin
                    if (hit_reg)
                    begin
                        do_delete = 1'b1;
                    end
                    else
                    begin
                        res.status = ST_UNKNOWN;
                    end
                end
                AK_REGISTER:
                begin
                    if (hit_reg)
                    begin
                        res.status = ST_DUPLICATE;
                    end
                    else if (!fits_reg && !item_reg.during_setup)
                    begin
                        res.status = ST_OVERFLOW;
                    end
                    else if (fits_reg && !free_reg)
                    begin
                        res.status = ST_FULL;
                    end
                    else
                    begin
                        // stored entry, or setup overflow resolving to its own value
                        do_store             = fits_reg;
                        res.newly_registered = fits_reg;
                        res.resolved_valid   = 1'b1;
                        res.resolved_kind    = item_reg.token_kind;
                        res.resolved_handle  = item_reg.value_handle;
                        res.resolved_bytes   = item_reg.value_bytes;
                    end
                end
                AK_USE_ALIAS:
                begin
                    if (!hit_reg)
                    begin
                        res.status = ST_UNKNOWN;
                    end
                    else if (expired_reg[hit_idx_reg])
                    begin
                        res.status = ST_EXPIRED;
                    end
                    else
                    begin
                        res.resolved_valid  = 1'b1;
                        res.resolved_kind   = rd_kind;
                        res.resolved_handle = rd_handle;
                        res.resolved_bytes  = rd_bytes;
                    end
                end
                AK_USE_VALUE:
                begin
                    res.resolved_valid  = 1'b1;
                    res.resolved_kind   = item_reg.token_kind;
                    res.resolved_handle = item_reg.value_handle;
                    res.resolved_bytes  = item_reg.value_bytes;
                end
                default:
                begin
                    res.status = ST_INVALID;
                end
            endcase
        end
    end

    assign ram_we = cmd.execute && do_store;

    // ---- table updates ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            used_bytes_reg <= '0;
        end
        else if (cmd.execute)
        begin
            if (do_delete)
            begin
                used_reg[hit_idx_reg] <= 1'b0;
                used_bytes_reg <= used_bytes_reg - 32'({1'b0, rd_bytes} + ENTRY_OVERHEAD);
            end
            else if (do_store)
            begin
                used_reg[free_idx_reg] <= 1'b1;
                used_bytes_reg         <= used_bytes_reg + esize;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            if (do_mark)
            begin
                expired_reg[hit_idx_reg] <= 1'b1;
            end
            else if (do_store)
            begin
                expired_reg[free_idx_reg] <= 1'b0;
                alias_reg[free_idx_reg]   <= item_reg.alias_number;
            end
        end
    end

    // ---- output register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.execute)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            rsp_reg <= res;
        end
    end

    assign sts.rsp_pending = rsp_valid_reg && !rsp_ready;
    assign rsp_valid       = rsp_valid_reg;
    assign rsp             = rsp_reg;

endmodule

@@ hdl/atac_checker.sv @@
// ----------------------------------------------------------------------------
// atac_checker
// Port-level checks of the alias cache, bound to the top level.
// ----------------------------------------------------------------------------
module atac_checker
    import atac_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [2:0] rsp_status,
    input logic       rsp_resolved_valid,
    input logic       rsp_newly_registered
);

    // one item in flight: no request taken right after a transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while an item is in flight");

    // a new entry always resolves with status ok
    a_reg_resolves: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_newly_registered) |-> (rsp_resolved_valid
            && rsp_status == ST_OK))
        else $error("new entry without ok resolved result");

    // resolved token only with ok status
    a_resolved_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_resolved_valid) |-> (rsp_status == ST_OK))
        else $error("resolved token with error status");

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
            && $stable(rsp_resolved_valid) && $stable(rsp_newly_registered)))
        else $error("stalled response changed");

endmodule

bind auth_token_alias_cache_unit atac_checker u_atac_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .req_valid            (req.valid),
    .req_ready            (req.ready),
    .rsp_valid            (rsp.valid),
    .rsp_ready            (rsp.ready),
    .rsp_status           (rsp.status),
    .rsp_resolved_valid   (rsp.resolved_valid),
    .rsp_newly_registered (rsp.newly_registered)
);
